### hdl/lifo_pkg.sv
package lifo_pkg;

    // Stack geometry
    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int DATA_W = 32;
    localparam int FILL_W = 7;
    localparam int POS_W  = 7;
    localparam int KIND_W = 3;
    localparam int STAT_W = 2;

    // Stream packing
    localparam int S_TDATA_W = ((DATA_W + POS_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((STAT_W + DATA_W + FILL_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - STAT_W - DATA_W - FILL_W;

    // Operation codes on s_tuser
    localparam logic [KIND_W-1:0] KIND_PUSH    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_POP     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DISPLAY = 3'd2;
    localparam logic [KIND_W-1:0] KIND_PEEP    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CHANGE  = 3'd4;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_OVER   = 2'd1;
    localparam logic [STAT_W-1:0] ST_UNDER  = 2'd2;
    localparam logic [STAT_W-1:0] ST_BADPOS = 2'd3;

    // Datapath commands
    typedef enum logic [2:0] {
        OP_NONE,
        OP_PUSH,
        OP_POP,
        OP_DISP_START,
        OP_DISP_NEXT,
        OP_PEEP,
        OP_CHANGE,
        OP_ERR
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [STAT_W-1:0] err;
    } dp_cmd_t;

    typedef struct packed {
        logic              empty;
        logic              full;
        logic              pos_ok;
        logic              last;
        logic [FILL_W-1:0] fill;
    } dp_stat_t;

endpackage

### hdl/lifo_stack_with_indexed_access_unit.sv
// Bounded stack of 64 signed 32-bit words driven by one operation per input
// transaction (push, pop, display, peep, change), selected on s_tuser. Each
// operation returns one result transaction carrying status, data and the
// fill level after the operation, with tlast on its final result; display
// returns one result per held entry, top first. One operation is handled at
// a time: push, change and every error result go from acceptance straight
// to the result state, while pop, peep and each display entry first pass
// through a read state for the registered read of the single stack memory,
// which sits between acceptance and the result. Unused kinds are absorbed
// with no result. The memory needs no clearing after reset.
module lifo_stack_with_indexed_access_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [lifo_pkg::S_TDATA_W-1:0]   s_tdata,  // value[31:0], position[38:32]
    input  logic [lifo_pkg::KIND_W-1:0]      s_tuser,  // kind
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [lifo_pkg::M_TDATA_W-1:0]   m_tdata,  // status[1:0], data[33:2], fill[40:34]
    output logic                             m_tlast   // last
);
    import lifo_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    lifo_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .kind     (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lifo_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .value    (s_tdata[DATA_W-1:0]),
        .position (s_tdata[DATA_W+POS_W-1:DATA_W]),
        .stat     (stat),
        .res_data (m_tdata)
    );

    assign m_tlast = stat.last;

    // Fill level never passes the stack depth
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.fill <= FILL_W'(DEPTH))
        else $error("stack fill above depth");

    // Input and output are never open together
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input taken while a result is pending");

    // A push into a stack with room grows it by one
    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == KIND_PUSH && !stat.full)
        |=> stat.fill == $past(stat.fill) + FILL_W'(1))
        else $error("push did not grow the stack");

    // A pop from a non-empty stack shrinks it by one
    a_pop_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == KIND_POP && !stat.empty)
        |=> stat.fill == $past(stat.fill) - FILL_W'(1))
        else $error("pop did not shrink the stack");

endmodule

### hdl/lifo_ram.sv
module lifo_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read, held while re is low
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/lifo_dp.sv
module lifo_dp (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  lifo_pkg::dp_cmd_t                      cmd,
    input  logic [lifo_pkg::DATA_W-1:0]            value,
    input  logic [lifo_pkg::POS_W-1:0]             position,
    output lifo_pkg::dp_stat_t                     stat,
    output logic [lifo_pkg::M_TDATA_W-1:0]         res_data
);
    import lifo_pkg::*;

    logic [FILL_W-1:0] count_reg, count_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic              last_reg, last_next;
    logic              mem_sel_reg, mem_sel_next;

    logic [FILL_W-1:0] top_slot;
    logic [FILL_W-1:0] pos_slot;
    logic              we, re;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [DATA_W-1:0] rdata;
    logic [DATA_W-1:0] out_word;

    assign top_slot = count_reg - FILL_W'(1);
    assign pos_slot = count_reg - position;

    // Status back to the controller
    assign stat.empty  = (count_reg == '0);
    assign stat.full   = (count_reg == FILL_W'(DEPTH));
    assign stat.pos_ok = (position != '0) && (position <= count_reg);
    assign stat.last   = last_reg;
    assign stat.fill   = count_reg;

    // Command decode
    always_comb begin
        count_next   = count_reg;
        idx_next     = idx_reg;
        status_next  = status_reg;
        last_next    = last_reg;
        mem_sel_next = mem_sel_reg;
        we           = 1'b0;
        re           = 1'b0;
        waddr        = count_reg[ADDR_W-1:0];
        raddr        = top_slot[ADDR_W-1:0];
        unique case (cmd.op)
            OP_PUSH: begin
                we           = 1'b1;
                count_next   = count_reg + FILL_W'(1);
                status_next  = ST_OK;
                last_next    = 1'b1;
                mem_sel_next = 1'b0;
            end
            OP_POP: begin
                re           = 1'b1;
                count_next   = top_slot;
                status_next  = ST_OK;
                last_next    = 1'b1;
                mem_sel_next = 1'b1;
            end
            OP_DISP_START: begin
                re           = 1'b1;
                idx_next     = top_slot[ADDR_W-1:0];
                status_next  = ST_OK;
                last_next    = (top_slot == '0);
                mem_sel_next = 1'b1;
            end
            OP_DISP_NEXT: begin
                re           = 1'b1;
                raddr        = idx_reg - ADDR_W'(1);
                idx_next     = idx_reg - ADDR_W'(1);
                last_next    = (idx_reg == ADDR_W'(1));
            end
            OP_PEEP: begin
                re           = 1'b1;
                raddr        = pos_slot[ADDR_W-1:0];
                status_next  = ST_OK;
                last_next    = 1'b1;
                mem_sel_next = 1'b1;
            end
            OP_CHANGE: begin
                we           = 1'b1;
                waddr        = pos_slot[ADDR_W-1:0];
                status_next  = ST_OK;
                last_next    = 1'b1;
                mem_sel_next = 1'b0;
            end
            OP_ERR: begin
                status_next  = cmd.err;
                last_next    = 1'b1;
                mem_sel_next = 1'b0;
            end
            OP_NONE: begin
            end
            default: begin
            end
        endcase
    end

    // Entry count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Result registers
    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        status_reg  <= status_next;
        last_reg    <= last_next;
        mem_sel_reg <= mem_sel_next;
    end

    lifo_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (value),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign out_word = mem_sel_reg ? rdata : '0;
    assign res_data = {M_PAD_W'(0), count_reg, out_word, status_reg};

endmodule

### hdl/lifo_ctrl.sv
module lifo_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [lifo_pkg::KIND_W-1:0] kind,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    input  lifo_pkg::dp_stat_t          stat,
    output lifo_pkg::dp_cmd_t           cmd
);
    import lifo_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_OUT  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // Next state and command
    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        cmd.err    = ST_OK;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    unique case (kind)
                        KIND_PUSH: begin
                            state_next = S_OUT;
                            if (stat.full) begin
                                cmd.op  = OP_ERR;
                                cmd.err = ST_OVER;
                            end else begin
                                cmd.op = OP_PUSH;
                            end
                        end
                        KIND_POP: begin
                            if (stat.empty) begin
                                cmd.op     = OP_ERR;
                                cmd.err    = ST_UNDER;
                                state_next = S_OUT;
                            end else begin
                                cmd.op     = OP_POP;
                                state_next = S_READ;
                            end
                        end
                        KIND_DISPLAY: begin
                            if (stat.empty) begin
                                cmd.op     = OP_ERR;
                                cmd.err    = ST_UNDER;
                                state_next = S_OUT;
                            end else begin
                                cmd.op     = OP_DISP_START;
                                state_next = S_READ;
                            end
                        end
                        KIND_PEEP, KIND_CHANGE: begin
                            priority if (stat.empty) begin
                                cmd.op     = OP_ERR;
                                cmd.err    = ST_UNDER;
                                state_next = S_OUT;
                            end else if (!stat.pos_ok) begin
                                cmd.op     = OP_ERR;
                                cmd.err    = ST_BADPOS;
                                state_next = S_OUT;
                            end else if (kind == KIND_PEEP) begin
                                cmd.op     = OP_PEEP;
                                state_next = S_READ;
                            end else begin
                                cmd.op     = OP_CHANGE;
                                state_next = S_OUT;
                            end
                        end
                        default: begin
                            // unused kinds are dropped
                        end
                    endcase
                end
            end
            S_READ: begin
                state_next = S_OUT;
            end
            S_OUT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    if (stat.last) begin
                        state_next = S_IDLE;
                    end else begin
                        cmd.op     = OP_DISP_NEXT;
                        state_next = S_READ;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### bench/lifo_stack_with_indexed_access_unit_test.sv
`timescale 1ns / 100ps

import lifo_pkg::*;

// One expected result transaction
typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] data;
    logic [FILL_W-1:0] fill;
    logic              last;
} stack_reply_t;

// Shadow copy of the stack: predicts the replies of each accepted operation
// and checks the replies coming out of the block in order.
class stack_shadow;
    logic [DATA_W-1:0] words[DEPTH];
    int unsigned       held;
    stack_reply_t      replies_due[$];
    int unsigned       fail_count;
    int unsigned       reported;

    function new();
        held       = 0;
        fail_count = 0;
        reported   = 0;
    endfunction

    function void queue_reply(logic [STAT_W-1:0] st, logic [DATA_W-1:0] d, logic l);
        stack_reply_t r;
        r.status = st;
        r.data   = d;
        r.fill   = held[FILL_W-1:0];
        r.last   = l;
        replies_due.push_back(r);
    endfunction

    // Predict the replies of one accepted operation
    function void apply_op(logic [KIND_W-1:0] kind, logic [DATA_W-1:0] value,
                           logic [POS_W-1:0] position);
        int unsigned slot;
        case (kind)
            KIND_PUSH: begin
                if (held >= DEPTH) begin
                    queue_reply(ST_OVER, '0, 1'b1);
                end else begin
                    words[held] = value;
                    held++;
                    queue_reply(ST_OK, '0, 1'b1);
                end
            end
            KIND_POP: begin
                if (held == 0) begin
                    queue_reply(ST_UNDER, '0, 1'b1);
                end else begin
                    held--;
                    queue_reply(ST_OK, words[held], 1'b1);
                end
            end
            KIND_DISPLAY: begin
                if (held == 0) begin
                    queue_reply(ST_UNDER, '0, 1'b1);
                end else begin
                    for (int k = 0; k < held; k++)
                        queue_reply(ST_OK, words[held-1-k], k == held - 1);
                end
            end
            KIND_PEEP, KIND_CHANGE: begin
                if (held == 0) begin
                    queue_reply(ST_UNDER, '0, 1'b1);
                end else if (position == 0 || position > held) begin
                    queue_reply(ST_BADPOS, '0, 1'b1);
                end else begin
                    slot = held - position;
                    if (kind == KIND_PEEP) begin
                        queue_reply(ST_OK, words[slot], 1'b1);
                    end else begin
                        words[slot] = value;
                        queue_reply(ST_OK, '0, 1'b1);
                    end
                end
            end
            default: ; // unused kinds leave the stack alone
        endcase
    endfunction

    function void mismatch(string field, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
        fail_count++;
        if (reported < 40) begin
            reported++;
            $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
        end
    endfunction

    // Compare one result transaction with the oldest expectation
    function void check_reply(logic [STAT_W-1:0] st, logic [DATA_W-1:0] d,
                              logic [FILL_W-1:0] f, logic l);
        stack_reply_t want;
        if (replies_due.size() == 0) begin
            fail_count++;
            if (reported < 40) begin
                reported++;
                $display("%0t ns: unexpected result, expected none, got status %0d data 0x%0h",
                         $time, st, d);
            end
            return;
        end
        want = replies_due.pop_front();
        if (st !== want.status) mismatch("status", DATA_W'(want.status), DATA_W'(st));
        if (d  !== want.data)   mismatch("data",   want.data,            d);
        if (f  !== want.fill)   mismatch("fill",   DATA_W'(want.fill),   DATA_W'(f));
        if (l  !== want.last)   mismatch("last",   DATA_W'(want.last),   DATA_W'(l));
    endfunction

    function int unsigned pending();
        return replies_due.size();
    endfunction
endclass

module lifo_stack_with_indexed_access_unit_test;

    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic [KIND_W-1:0]     s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;

    stack_shadow shadow = new();
    int unsigned ops_accepted = 0;
    int unsigned idle_cycles  = 0;

    lifo_stack_with_indexed_access_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #2 aclk = ~aclk;

    // Mostly short gaps, a few long, none at all in some stretches
    function automatic int pick_gap(bit quiet);
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [DATA_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '1;
            3: return '0;
            default: return $urandom;
        endcase
    endfunction

    // Mostly a valid position, sometimes anything the field holds
    function automatic logic [POS_W-1:0] pick_pos();
        if (shadow.held > 0 && $urandom_range(0, 4) != 0)
            return POS_W'($urandom_range(1, shadow.held));
        return POS_W'($urandom_range(0, 127));
    endfunction

    // Offer one operation and wait for its transaction
    task automatic send_op(logic [KIND_W-1:0] kind, logic [DATA_W-1:0] value,
                           logic [POS_W-1:0] position);
        int gap;
        gap = pick_gap((ops_accepted % 50) < 12);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {{(S_TDATA_W-DATA_W-POS_W){1'b0}}, position, value};
        do @(posedge aclk); while (!s_tready);
        shadow.apply_op(kind, value, position);
        ops_accepted++;
    endtask

    task automatic send_random_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)      send_op(KIND_PUSH,    pick_word(), pick_pos());
        else if (r < 50) send_op(KIND_POP,     pick_word(), pick_pos());
        else if (r < 58) send_op(KIND_DISPLAY, pick_word(), pick_pos());
        else if (r < 77) send_op(KIND_PEEP,    pick_word(), pick_pos());
        else if (r < 96) send_op(KIND_CHANGE,  pick_word(), pick_pos());
        else             send_op(KIND_W'($urandom_range(5, 7)), pick_word(), pick_pos());
    endtask

    // Receiver: random ready pattern, with one long hold-off early on
    initial begin
        bit held_off;
        held_off = 1'b0;
        @(posedge aresetn);
        forever begin
            if (!held_off && ops_accepted >= 30) begin
                held_off = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
            if ((ops_accepted % 40) >= 10) begin
                int gap;
                gap = pick_gap(1'b0);
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
    end

    // Result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            shadow.check_reply(m_tdata[STAT_W-1:0], m_tdata[STAT_W +: DATA_W],
                               m_tdata[STAT_W+DATA_W +: FILL_W], m_tlast);
    end

    // Watchdog: cycles without any transaction
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus
    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty stack, extremes, bad positions, unused kinds
        send_op(KIND_POP,     '0, 7'd1);
        send_op(KIND_DISPLAY, '0, 7'd0);
        send_op(KIND_PEEP,    '0, 7'd1);
        send_op(KIND_CHANGE,  '1, 7'd1);
        send_op(KIND_PUSH,    32'h8000_0000, 7'd0);
        send_op(KIND_PUSH,    32'h7fff_ffff, 7'd127);
        send_op(KIND_PUSH,    '1, 7'd0);
        send_op(KIND_PUSH,    '0, 7'd0);
        send_op(KIND_DISPLAY, '0, 7'd0);
        send_op(KIND_PEEP,    '0, 7'd0);
        send_op(KIND_PEEP,    '0, 7'd1);
        send_op(KIND_PEEP,    '0, 7'd4);
        send_op(KIND_PEEP,    '0, 7'd5);
        send_op(KIND_PEEP,    '0, 7'd127);
        send_op(KIND_CHANGE,  32'h5555_5555, 7'd2);
        send_op(KIND_CHANGE,  32'haaaa_aaaa, 7'd0);
        send_op(KIND_CHANGE,  32'haaaa_aaaa, 7'd64);
        send_op(3'd5,         32'h1234_5678, 7'd1);
        send_op(3'd6,         '0, 7'd0);
        send_op(3'd7,         '1, 7'd127);
        send_op(KIND_PEEP,    '0, 7'd2);
        send_op(KIND_POP,     '0, 7'd0);
        send_op(KIND_DISPLAY, '0, 7'd0);

        // Fill to the top with indexed accesses mixed in, then overflow
        while (shadow.held < DEPTH) begin
            case ($urandom_range(0, 15))
                0:       send_op(KIND_PEEP,   pick_word(), pick_pos());
                1:       send_op(KIND_CHANGE, pick_word(), pick_pos());
                default: send_op(KIND_PUSH,   pick_word(), pick_pos());
            endcase
        end
        send_op(KIND_PUSH,    pick_word(), pick_pos());
        send_op(KIND_PUSH,    pick_word(), pick_pos());
        send_op(KIND_DISPLAY, pick_word(), pick_pos());
        send_op(KIND_PEEP,    '0, 7'd64);
        send_op(KIND_CHANGE,  pick_word(), 7'd64);
        send_op(KIND_PEEP,    '0, 7'd65);
        send_op(KIND_DISPLAY, '0, 7'd0);

        // Random mix around the full level
        repeat (12) send_random_op();

        // Take a few entries off the top, then a last display
        repeat (4) send_op(KIND_POP, pick_word(), pick_pos());
        send_op(KIND_DISPLAY, pick_word(), pick_pos());
        send_random_op();
        s_tvalid <= 1'b0;

        // Let the last replies arrive, then watch for strays
        while (shadow.pending() != 0) @(posedge aclk);
        repeat (2 * DEPTH + 20) @(posedge aclk);

        if (shadow.fail_count == 0 && shadow.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/lifo_pkg.sv
hdl/lifo_ram.sv
hdl/lifo_dp.sv
hdl/lifo_ctrl.sv
hdl/lifo_stack_with_indexed_access_unit.sv
bench/lifo_stack_with_indexed_access_unit_test.sv
